[sv/accel_state_to_polar_core_defines.svh]
// Assertion macros used by the core to check its behaviour.
`ifndef ACCEL_STATE_TO_POLAR_CORE_DEFINES_SVH
`define ACCEL_STATE_TO_POLAR_CORE_DEFINES_SVH

// Implication checked on every rising edge of clk outside reset.
`define ASP_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Condition that must never hold outside reset.
`define ASP_ASSERT_NEVER(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("forbidden condition seen");

`endif

[sv/asp_pkg.sv]
// Types, constants and the arctangent table of the state to polar converter.
package asp_pkg;

	// Width of the CORDIC x and y words (inputs scaled by 2^24, plus gain headroom).
	localparam int CW = 60;
	// One root cell per result bit of a 64-bit radicand.
	localparam int SQRT_CELLS = 32;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic [31:0]          z;
		logic                 zero;
	} cord_t;

	typedef struct packed {
		logic [63:0] n;
		logic [63:0] res;
	} sqrt_t;

	// atan(2^-i) with a full turn equal to 2^32.
	function automatic logic [31:0] atan_step(input int i);
		logic [31:0] r;
		unique case (i)
			0:  r = 32'h20000000;
			1:  r = 32'h12E4051E;
			2:  r = 32'h09FB385B;
			3:  r = 32'h051111D4;
			4:  r = 32'h028B0D43;
			5:  r = 32'h0145D7E1;
			6:  r = 32'h00A2F61E;
			7:  r = 32'h00517C55;
			8:  r = 32'h0028BE53;
			9:  r = 32'h00145F2F;
			10: r = 32'h000A2F98;
			11: r = 32'h000517CC;
			12: r = 32'h00028BE6;
			13: r = 32'h000145F3;
			14: r = 32'h0000A2FA;
			15: r = 32'h0000517D;
			16: r = 32'h000028BE;
			17: r = 32'h0000145F;
			18: r = 32'h00000A30;
			19: r = 32'h00000518;
			20: r = 32'h0000028C;
			21: r = 32'h00000146;
			22: r = 32'h000000A3;
			23: r = 32'h00000051;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

endpackage

[sv/accel_state_to_polar_core.sv]
// Throughput: one request per cycle; busy is never raised.
// The done strobe follows two product stages, the 32-cell square root chain and an output register;
// the CORDIC_STAGES-cell CORDIC chain runs beside the root chain and is delayed to match.
// Reset clears only the valid chain; data registers carry no reset.
// The receiver cannot stall: each result is shown for exactly one cycle.
`include "accel_state_to_polar_core_defines.svh"

module accel_state_to_polar_core #(
	parameter int CORDIC_STAGES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] vel_x,
	input  logic signed [31:0] vel_y,
	input  logic signed [31:0] acc_x,
	input  logic signed [31:0] acc_y,
	output logic               done,
	output logic signed [15:0] heading,
	output logic [63:0]        speed_squared,
	output logic signed [32:0] accel_along
);

	localparam int VLEN = 2 + asp_pkg::SQRT_CELLS;
	localparam int LAT  = VLEN + 1;
	localparam int HDLY = VLEN - 1 - CORDIC_STAGES;

	// Input stage: products and pre-rotated CORDIC start.
	logic [63:0]        sq_vx_s1, sq_vy_s1, sq_ax_s1, sq_ay_s1;
	logic signed [63:0] p_x_s1, p_y_s1;
	logic               zero_s1, ax_neg_s1;
	asp_pkg::cord_t     cord_in;
	asp_pkg::cord_t     cord_s1;
	logic signed [asp_pkg::CW-1:0] sx, sy;

	// Sums stage.
	logic [63:0]    speed_s2;
	logic           neg_s2;
	asp_pkg::sqrt_t root_s2;

	logic [VLEN-1:0] vld_q;
	logic            done_q;
	logic [15:0]     heading_q;
	logic [63:0]     speed_q;
	logic [32:0]     along_q;

	assign busy = 1'b0;

	// Scale by 2^24 and fold the left half plane onto the right.
	always_comb begin
		sx = asp_pkg::CW'(vel_x) <<< 24;
		sy = asp_pkg::CW'(vel_y) <<< 24;
		cord_in.zero = (vel_x == 32'sd0) && (vel_y == 32'sd0);
		if (vel_x[31]) begin
			if (!vel_y[31]) begin
				cord_in.x = sy;
				cord_in.y = -sx;
				cord_in.z = 32'h40000000;
			end else begin
				cord_in.x = -sy;
				cord_in.y = sx;
				cord_in.z = 32'hC0000000;
			end
		end else begin
			cord_in.x = sx;
			cord_in.y = sy;
			cord_in.z = 32'h00000000;
		end
	end

	// First stage registers: one multiplier per product, full 64-bit result.
	always_ff @(posedge clk) begin
		sq_vx_s1  <= vel_x * vel_x;
		sq_vy_s1  <= vel_y * vel_y;
		sq_ax_s1  <= acc_x * acc_x;
		sq_ay_s1  <= acc_y * acc_y;
		p_x_s1    <= vel_x * acc_x;
		p_y_s1    <= vel_y * acc_y;
		zero_s1   <= cord_in.zero;
		ax_neg_s1 <= acc_x[31];
		cord_s1   <= cord_in;
	end

	// Second stage: squared magnitudes and the sign of the dot product.
	always_ff @(posedge clk) begin
		speed_s2     <= sq_vx_s1 + sq_vy_s1;
		root_s2.n    <= sq_ax_s1 + sq_ay_s1;
		root_s2.res  <= 64'd0;
		if (zero_s1) begin
			neg_s2 <= ax_neg_s1;
		end else begin
			neg_s2 <= (65'(p_x_s1) + 65'(p_y_s1)) >> 64 != 65'd0;
		end
	end

	// CORDIC chain.
	asp_pkg::cord_t cord_c [CORDIC_STAGES+1];
	assign cord_c[0] = cord_s1;

	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
		asp_cordic_cell #(.STAGE(g)) u_cell (
			.clk   (clk),
			.din   (cord_c[g]),
			.dout_q(cord_c[g+1])
		);
	end

	// Round half up to the 16-bit binary angle; zero velocity gives zero.
	logic [31:0] z_rnd;
	logic [15:0] head_raw, head_dly;
	assign z_rnd    = cord_c[CORDIC_STAGES].z + 32'h00008000;
	assign head_raw = cord_c[CORDIC_STAGES].zero ? 16'd0 : z_rnd[31:16];

	asp_delay #(.WIDTH(16), .DEPTH(HDLY)) u_head_dly (
		.clk (clk),
		.din (head_raw),
		.dout(head_dly)
	);

	// Square root chain.
	asp_pkg::sqrt_t root_c [asp_pkg::SQRT_CELLS+1];
	assign root_c[0] = root_s2;

	for (genvar g = 0; g < asp_pkg::SQRT_CELLS; g++) begin : g_sqrt
		asp_sqrt_cell #(.STEP(g)) u_cell (
			.clk   (clk),
			.din   (root_c[g]),
			.dout_q(root_c[g+1])
		);
	end

	// Speed and sign ride alongside the root chain.
	logic [64:0] side_dly;
	asp_delay #(.WIDTH(65), .DEPTH(asp_pkg::SQRT_CELLS)) u_side_dly (
		.clk (clk),
		.din ({neg_s2, speed_s2}),
		.dout(side_dly)
	);

	// Valid chain, one bit per pipeline stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			done_q <= 1'b0;
		end else begin
			vld_q  <= {vld_q[VLEN-2:0], start};
			done_q <= vld_q[VLEN-1];
		end
	end

	// Output registers with the sign applied to the root.
	logic [32:0] amag;
	assign amag = root_c[asp_pkg::SQRT_CELLS].res[32:0];

	always_ff @(posedge clk) begin
		heading_q <= head_dly;
		speed_q   <= side_dly[63:0];
		along_q   <= side_dly[64] ? (33'd0 - amag) : amag;
	end

	assign done          = done_q;
	assign heading       = heading_q;
	assign speed_squared = speed_q;
	assign accel_along   = along_q;

	// Checks on the pipeline.
	`ASP_ASSERT_NEVER(a_never_busy, busy)
	`ASP_ASSERT_IMP(a_latency, start, ##LAT done)
	`ASP_ASSERT_IMP(a_zero_heading, start && vel_x == 32'sd0 && vel_y == 32'sd0, ##LAT heading == 16'sd0)

endmodule

[sv/asp_cordic_cell.sv]
// One vectoring CORDIC rotation stage with its output register.
module asp_cordic_cell #(
	parameter int STAGE = 0
) (
	input  logic           clk,
	input  asp_pkg::cord_t din,
	output asp_pkg::cord_t dout_q
);

	logic signed [asp_pkg::CW-1:0] xs;
	logic signed [asp_pkg::CW-1:0] ys;

	// Shifted terms floor towards minus infinity.
	assign xs = din.x >>> STAGE;
	assign ys = din.y >>> STAGE;

	// Rotate towards the x axis, steering by the sign of y.
	always_ff @(posedge clk) begin
		dout_q.zero <= din.zero;
		if (!din.y[asp_pkg::CW-1]) begin
			dout_q.x <= din.x + ys;
			dout_q.y <= din.y - xs;
			dout_q.z <= din.z + asp_pkg::atan_step(STAGE);
		end else begin
			dout_q.x <= din.x - ys;
			dout_q.y <= din.y + xs;
			dout_q.z <= din.z - asp_pkg::atan_step(STAGE);
		end
	end

endmodule

[sv/asp_sqrt_cell.sv]
// One step of the digit-by-digit floor square root with its output register.
module asp_sqrt_cell #(
	parameter int STEP = 0
) (
	input  logic           clk,
	input  asp_pkg::sqrt_t din,
	output asp_pkg::sqrt_t dout_q
);

	localparam logic [63:0] BIT = 64'(1) << (62 - 2 * STEP);

	logic [63:0] trial;

	assign trial = din.res + BIT;

	// Subtract the trial value when it fits and set this result bit.
	always_ff @(posedge clk) begin
		if (din.n >= trial) begin
			dout_q.n   <= din.n - trial;
			dout_q.res <= (din.res >> 1) + BIT;
		end else begin
			dout_q.n   <= din.n;
			dout_q.res <= din.res >> 1;
		end
	end

endmodule

[sv/asp_delay.sv]
// Fixed-length shift register that keeps side data in step with the pipeline.
module asp_delay #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1
) (
	input  logic             clk,
	input  logic [WIDTH-1:0] din,
	output logic [WIDTH-1:0] dout
);

	logic [WIDTH-1:0] tap_q [DEPTH];

	// Shift every tap along by one each cycle.
	always_ff @(posedge clk) begin
		tap_q[0] <= din;
		for (int i = 1; i < DEPTH; i++) begin
			tap_q[i] <= tap_q[i-1];
		end
	end

	assign dout = tap_q[DEPTH-1];

endmodule
